// ----- src/ecpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpi_pkg - shared types and constants of the color palette indexer
// Field widths, register indexes, status codes and the control flags that
// travel with a probe along the cell chain.
// ----------------------------------------------------------------------------
package ecpi_pkg;

    // Field widths
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned USED_W     = 5;
    localparam int unsigned LIMIT_W    = 5;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_LIMIT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSP_EN    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSP_COLOR = 2'd2;

    // Register reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INDEXED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRANSPARENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd2;

    // Control flags carried by a probe from cell to cell
    typedef struct packed {
        logic live;   // a probe occupies this stage
        logic skip;   // transparent pixel: no compare, no append
        logic room;   // palette below its limit when the item entered
        logic found;  // index settled (match or append)
        logic added;  // a new color was appended
    } t_probe_ctl;

endpackage

// ----- src/ecpi_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpi_ifs - handshake channels of the color palette indexer
// Pixel input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ecpi_pix_if;
    logic                             valid;
    logic                             ready;
    logic [ecpi_pkg::CHAN_W-1:0]      pixel_red;
    logic [ecpi_pkg::CHAN_W-1:0]      pixel_green;
    logic [ecpi_pkg::CHAN_W-1:0]      pixel_blue;
    logic                             start_of_image;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, start_of_image,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, start_of_image,
                    output ready);
endinterface

interface ecpi_res_if;
    logic                             valid;
    logic                             ready;
    logic [ecpi_pkg::INDEX_W-1:0]     pal_index;
    logic [ecpi_pkg::STATUS_W-1:0]    status;
    logic                             new_entry;
    logic [ecpi_pkg::USED_W-1:0]      entries_used;

    modport source (output valid, pal_index, status, new_entry, entries_used,
                    input ready);
    modport sink   (input valid, pal_index, status, new_entry, entries_used,
                    output ready);
endinterface

interface ecpi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ecpi_pkg::CFG_ADDR_W-1:0]  index;
    logic [ecpi_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ecpi_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpi_cell - one palette entry of the cell chain
// Holds one stored color. A passing probe is compared against it while the
// entry is occupied; the first free cell appends the color if there is room.
// The probe is registered and handed to the next cell.
// ----------------------------------------------------------------------------
module ecpi_cell #(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  ecpi_pkg::t_probe_ctl             i_ctl,
    input  logic [ecpi_pkg::COLOR_W-1:0]     i_pixel,
    input  logic [IDX_W-1:0]                 i_pos,
    input  logic [IDX_W-1:0]                 i_idx,
    input  logic [CNT_W-1:0]                 i_left,
    output ecpi_pkg::t_probe_ctl             o_ctl,
    output logic [ecpi_pkg::COLOR_W-1:0]     o_pixel,
    output logic [IDX_W-1:0]                 o_pos,
    output logic [IDX_W-1:0]                 o_idx,
    output logic [CNT_W-1:0]                 o_left
);

    logic [ecpi_pkg::COLOR_W-1:0] r_entry;
    ecpi_pkg::t_probe_ctl         r_ctl;
    ecpi_pkg::t_probe_ctl         n_ctl;
    logic [ecpi_pkg::COLOR_W-1:0] r_pixel;
    logic [IDX_W-1:0]             r_pos;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             n_idx;
    logic [CNT_W-1:0]             r_left;
    logic [CNT_W-1:0]             n_left;
    logic                         w_occupied;
    logic                         w_test;
    logic                         w_hit;
    logic                         w_append;

    // Compare or append decision for this entry
    assign w_occupied = (i_left != '0);
    assign w_test     = i_ctl.live && !i_ctl.skip && !i_ctl.found;
    assign w_hit      = w_test && w_occupied && (r_entry == i_pixel);
    assign w_append   = w_test && !w_occupied && i_ctl.room;

    // Probe update handed to the next cell
    always_comb begin
        n_ctl       = i_ctl;
        n_idx       = i_idx;
        n_ctl.added = i_ctl.added | w_append;
        if (w_hit || w_append) begin
            n_ctl.found = 1'b1;
            n_idx       = i_pos;
        end
        n_left = w_occupied ? (i_left - CNT_W'(1)) : i_left;
    end

    // Probe stage, live flag cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pixel <= i_pixel;
            r_pos   <= i_pos + IDX_W'(1);
            r_idx   <= n_idx;
            r_left  <= n_left;
        end
    end

    // Stored color, written only by an append
    always_ff @(posedge i_clk) begin
        if (i_adv && w_append) begin
            r_entry <= i_pixel;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_pixel = r_pixel;
    assign o_pos   = r_pos;
    assign o_idx   = r_idx;
    assign o_left  = r_left;

endmodule

// ----- src/exact_color_palette_indexer.sv -----
`timescale 1ns / 1ps
// A pixel item's probe walks the cell chain, one entry per cycle while the chain
// is not held, and its result is loaded into the output register as it leaves.
// The next item is accepted only once the probe has left the chain.
// A result waiting at the output stalls the chain only if the probe reaches the end.
// Reset (synchronous, active low) empties the palette and restores the registers;
// no clearing pass, the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// exact_color_palette_indexer - exact-match color palette builder
// Indexes each pixel against a palette of distinct colors built on the fly,
// with transparent-key skipping, a configurable color limit and overflow status.
// ----------------------------------------------------------------------------
module exact_color_palette_indexer #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecpi_pix_if.sink          i_pix,
    ecpi_res_if.source        o_res,
    ecpi_cfg_if.sink          i_cfg
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    // Configuration registers
    logic [ecpi_pkg::LIMIT_W-1:0]  r_limit;
    logic                          r_tr_en;
    logic [ecpi_pkg::COLOR_W-1:0]  r_tr_color;

    // Control state
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          r_busy;
    logic                          r_out_valid;

    // Result registers
    logic [ecpi_pkg::INDEX_W-1:0]  r_index;
    logic [ecpi_pkg::STATUS_W-1:0] r_status;
    logic                          r_new;
    logic [ecpi_pkg::USED_W-1:0]   r_used;

    // Chain wiring, stage 0 is the entry point
    ecpi_pkg::t_probe_ctl          w_ctl   [MAX_ENTRIES+1];
    logic [ecpi_pkg::COLOR_W-1:0]  w_pixel [MAX_ENTRIES+1];
    logic [IDX_W-1:0]              w_pos   [MAX_ENTRIES+1];
    logic [IDX_W-1:0]              w_idx   [MAX_ENTRIES+1];
    logic [CNT_W-1:0]              w_left  [MAX_ENTRIES+1];
    logic [MAX_ENTRIES:0]          w_live_vec;

    logic                          w_accept;
    logic                          w_adv;
    logic                          w_load;
    logic [CNT_W-1:0]              w_eff_count;
    logic [ecpi_pkg::COLOR_W-1:0]  w_key;
    logic [31:0]                   w_idx_ext;
    logic [31:0]                   w_used_ext;
    ecpi_pkg::t_probe_ctl          w_exit;

    // Handshakes
    assign i_pix.ready = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_pix.valid && !r_busy;

    // Probe entry: start-of-image clears the count before the lookup
    assign w_eff_count = i_pix.start_of_image ? '0 : r_count;
    assign w_key       = {i_pix.pixel_red, i_pix.pixel_green, i_pix.pixel_blue};

    always_comb begin
        w_ctl[0].live  = w_accept;
        w_ctl[0].skip  = r_tr_en && (w_key == r_tr_color);
        w_ctl[0].room  = (32'(w_eff_count) < 32'(r_limit)) &&
                         (32'(w_eff_count) < 32'(MAX_ENTRIES));
        w_ctl[0].found = 1'b0;
        w_ctl[0].added = 1'b0;
    end

    assign w_pixel[0] = w_key;
    assign w_pos[0]   = '0;
    assign w_idx[0]   = '0;
    assign w_left[0]  = w_eff_count;

    // Cell chain, one palette entry per cell
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            ecpi_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_ctl   (w_ctl[gi]),
                .i_pixel (w_pixel[gi]),
                .i_pos   (w_pos[gi]),
                .i_idx   (w_idx[gi]),
                .i_left  (w_left[gi]),
                .o_ctl   (w_ctl[gi+1]),
                .o_pixel (w_pixel[gi+1]),
                .o_pos   (w_pos[gi+1]),
                .o_idx   (w_idx[gi+1]),
                .o_left  (w_left[gi+1])
            );
        end
        for (gi = 0; gi <= MAX_ENTRIES; gi++) begin : g_live
            assign w_live_vec[gi] = w_ctl[gi].live;
        end
    endgenerate

    // Chain exit: hold the chain only when a finished probe meets a full output
    assign w_exit     = w_ctl[MAX_ENTRIES];
    assign w_adv      = !(w_exit.live && r_out_valid && !o_res.ready);
    assign w_load     = w_exit.live && w_adv;
    assign w_idx_ext  = 32'(w_idx[MAX_ENTRIES]);
    assign w_used_ext = 32'(r_count) + 32'(w_exit.added);

    // Entry count
    always_comb begin
        n_count = r_count;
        if (w_accept && i_pix.start_of_image) begin
            n_count = '0;
        end else if (w_load && w_exit.added) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= ecpi_pkg::LIMIT_RESET;
            r_tr_en    <= 1'b0;
            r_tr_color <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ecpi_pkg::REG_COLOR_LIMIT:  r_limit    <= i_cfg.data[ecpi_pkg::LIMIT_W-1:0];
                ecpi_pkg::REG_TRANSP_EN:    r_tr_en    <= i_cfg.data[0];
                ecpi_pkg::REG_TRANSP_COLOR: r_tr_color <= i_cfg.data[ecpi_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_index <= w_idx_ext[ecpi_pkg::INDEX_W-1:0];
            r_new   <= w_exit.added;
            r_used  <= w_used_ext[ecpi_pkg::USED_W-1:0];
            if (w_exit.skip) begin
                r_status <= ecpi_pkg::ST_TRANSPARENT;
            end else if (w_exit.found) begin
                r_status <= ecpi_pkg::ST_INDEXED;
            end else begin
                r_status <= ecpi_pkg::ST_OVERFLOW;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.pal_index    = r_index;
    assign o_res.status       = r_status;
    assign o_res.new_entry    = r_new;
    assign o_res.entries_used = r_used;

    // Checks
    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live_vec))
        else $error("more than one probe in the cell chain");

    a_busy_tracks_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (|w_live_vec[MAX_ENTRIES:1]))
        else $error("busy flag disagrees with the probe in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_ENTRIES))
        else $error("entry count beyond palette depth");

    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_exit.added) |-> (w_idx_ext == 32'(r_count)))
        else $error("append landed away from the first free entry");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule

// ----- tb/palette_index_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_index_checker - result predictor and checker for the palette indexer
// Watches the pixel, result and register channels. Keeps its own palette and
// register copy, predicts one result per accepted pixel and compares every
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module palette_index_checker #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ecpi_pix_if   i_pix,
    ecpi_res_if   i_res,
    ecpi_cfg_if   i_cfg,
    output int    o_mismatches,
    output int    o_pending,
    output int    o_indexed,
    output int    o_skipped,
    output int    o_overflows,
    output int    o_appends
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ecpi_pkg::INDEX_W-1:0]  pal_index;
        logic [ecpi_pkg::STATUS_W-1:0] status;
        logic                          new_entry;
        logic [ecpi_pkg::USED_W-1:0]   entries_used;
    } t_pixel_result;

    // Predicted palette and register copy
    logic [ecpi_pkg::COLOR_W-1:0] palette_copy [MAX_ENTRIES];
    int unsigned                  colors_held;
    logic [ecpi_pkg::LIMIT_W-1:0] color_limit;
    logic                         key_enable;
    logic [ecpi_pkg::COLOR_W-1:0] key_color;

    t_pixel_result      expected_results [$];
    int unsigned        results_seen;

    // Index one pixel against the palette copy, appending when there is room
    function automatic t_pixel_result index_pixel(input logic [ecpi_pkg::COLOR_W-1:0] rgb,
                                                  input logic sof);
        t_pixel_result outcome;
        int unsigned   cap;
        bit            hit;
        outcome = '0;
        hit     = 1'b0;
        if (sof) begin
            colors_held = 0;
        end
        cap = (color_limit > MAX_ENTRIES) ? MAX_ENTRIES : color_limit;
        if (key_enable && rgb == key_color) begin
            outcome.status = ecpi_pkg::ST_TRANSPARENT;
        end else begin
            for (int k = 0; k < colors_held; k++) begin
                if (!hit && palette_copy[k] == rgb) begin
                    outcome.pal_index = ecpi_pkg::INDEX_W'(k);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (colors_held >= cap) begin
                    outcome.status = ecpi_pkg::ST_OVERFLOW;
                end else begin
                    palette_copy[colors_held] = rgb;
                    outcome.pal_index         = ecpi_pkg::INDEX_W'(colors_held);
                    outcome.new_entry         = 1'b1;
                    colors_held++;
                end
            end
        end
        outcome.entries_used = ecpi_pkg::USED_W'(colors_held);
        return outcome;
    endfunction

    // Sample all three channels on the rising edge
    always @(posedge i_clk) begin
        t_pixel_result want;
        t_pixel_result got;
        if (!i_rst_n) begin
            colors_held  = 0;
            color_limit  = ecpi_pkg::LIMIT_RESET;
            key_enable   = 1'b0;
            key_color    = '0;
            results_seen = 0;
            expected_results.delete();
        end else begin
            // results first: a result always belongs to an older pixel
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                got.pal_index    = i_res.pal_index;
                got.status       = i_res.status;
                got.new_entry    = i_res.new_entry;
                got.entries_used = i_res.entries_used;
                results_seen++;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_MAX) begin
                        $display("%0t: result %0d arrived with nothing expected: index=%0d",
                                 $realtime, results_seen, got.pal_index,
                                 " status=%0d new=%0d used=%0d",
                                 got.status, got.new_entry, got.entries_used);
                    end
                end else begin
                    want = expected_results.pop_front();
                    case (want.status)
                        ecpi_pkg::ST_TRANSPARENT: o_skipped++;
                        ecpi_pkg::ST_OVERFLOW:    o_overflows++;
                        default:                  o_indexed++;
                    endcase
                    if (want.new_entry) begin
                        o_appends++;
                    end
                    if (got.pal_index !== want.pal_index ||
                            got.status !== want.status ||
                            got.new_entry !== want.new_entry ||
                            got.entries_used !== want.entries_used) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_MAX) begin
                            $display("%0t: result %0d expected index=%0d status=%0d",
                                     $realtime, results_seen, want.pal_index,
                                     want.status, " new=%0d used=%0d",
                                     want.new_entry, want.entries_used,
                                     ", got index=%0d status=%0d new=%0d used=%0d",
                                     got.pal_index, got.status, got.new_entry,
                                     got.entries_used);
                        end
                    end
                end
            end

            // register writes only while the block is idle: the user is bound, the block does not enforce it
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                case (i_cfg.index)
                    ecpi_pkg::REG_COLOR_LIMIT:
                        color_limit = i_cfg.data[ecpi_pkg::LIMIT_W-1:0];
                    ecpi_pkg::REG_TRANSP_EN:
                        key_enable  = i_cfg.data[0];
                    ecpi_pkg::REG_TRANSP_COLOR:
                        key_color   = i_cfg.data[ecpi_pkg::COLOR_W-1:0];
                    default: ;
                endcase
            end

            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1) begin
                expected_results.push_back(index_pixel(
                    {i_pix.pixel_red, i_pix.pixel_green, i_pix.pixel_blue},
                    i_pix.start_of_image));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/exact_color_palette_indexer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_color_palette_indexer_test - stimulus and verdict for the palette indexer
// Sends a short directed set of pixels and register settings, then random
// images drawn from small color pools under a sweep of limits and keys, with
// random idling on both sides, a no-idle stretch and one long output stall.
// ----------------------------------------------------------------------------
module exact_color_palette_indexer_test;

    localparam int unsigned MAX_ENTRIES  = 16;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_PIXELS = 100;
    localparam int unsigned POOL_MAX     = 20;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned END_LIMIT    = 20000;
    localparam int          WATCHDOG_NS  = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    ecpi_pix_if pix_ch ();
    ecpi_res_if res_ch ();
    ecpi_cfg_if cfg_ch ();

    int          mismatches;
    int          pending;
    int          indexed;
    int          skipped;
    int          overflows;
    int          appends;
    int unsigned pixels_sent;
    int unsigned reg_writes;
    bit          steady_stretch;
    bit          hold_request;

    exact_color_palette_indexer #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    palette_index_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) palette_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_indexed    (indexed),
        .o_skipped    (skipped),
        .o_overflows  (overflows),
        .o_appends    (appends)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Result side: random stalls, one long hold, and a stall-free stretch
    initial begin : result_receiver
        int unsigned hold_left;
        bit          held_once;
        hold_left    = 0;
        held_once    = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !held_once) begin
                held_once    = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (steady_stretch) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("watchdog expired, %0d results still outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one pixel item, with a random gap in front; returns at the accepting edge
    task automatic push_pixel(input logic [ecpi_pkg::COLOR_W-1:0] rgb, input logic sof);
        @(negedge i_clk);
        while (!steady_stretch && $urandom_range(99) < 30) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid          <= 1'b1;
        pix_ch.pixel_red      <= rgb[23:16];
        pix_ch.pixel_green    <= rgb[15:8];
        pix_ch.pixel_blue     <= rgb[7:0];
        pix_ch.start_of_image <= sof;
        @(posedge i_clk);
        while (pix_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        pixels_sent++;
    endtask

    // Wait until every predicted result has come back, then let the chain empty
    task automatic wait_idle();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (MAX_ENTRIES + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ecpi_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ecpi_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
    endtask

    // Channel value biased toward the extremes
    function automatic logic [ecpi_pkg::CHAN_W-1:0] pick_channel();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return ecpi_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [ecpi_pkg::COLOR_W-1:0] color_pool [POOL_MAX];
        logic [ecpi_pkg::COLOR_W-1:0] rgb;
        logic [ecpi_pkg::COLOR_W-1:0] key_pick;
        logic [ecpi_pkg::LIMIT_W-1:0] limit_pick;
        logic                         key_on;
        logic                         sof;
        int unsigned                  pool_n;
        int unsigned                  image_len;
        int unsigned                  phase_count;
        int unsigned                  spent;

        pixels_sent           = 0;
        reg_writes            = 0;
        steady_stretch        = 1'b0;
        hold_request          = 1'b0;
        pix_ch.valid          = 1'b0;
        pix_ch.pixel_red      = '0;
        pix_ch.pixel_green    = '0;
        pix_ch.pixel_blue     = '0;
        pix_ch.start_of_image = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = ecpi_pkg::REG_COLOR_LIMIT;
        cfg_ch.data           = '0;
        i_rst_n               = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes of the channels, appends and matches
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'hFF0000, 1'b0);
        push_pixel(24'h00FF00, 1'b0);
        push_pixel(24'h0000FF, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);

        // limit lowered below the count: stored colors match, new ones overflow
        wait_idle();
        write_reg(ecpi_pkg::REG_COLOR_LIMIT, 24'd2);
        push_pixel(24'h00FF00, 1'b0);
        push_pixel(24'h123456, 1'b0);

        // limit zero with white as key; key tested after the image clear
        wait_idle();
        write_reg(ecpi_pkg::REG_COLOR_LIMIT, 24'd0);
        write_reg(ecpi_pkg::REG_TRANSP_EN, 24'd1);
        write_reg(ecpi_pkg::REG_TRANSP_COLOR, 24'hFFFFFF);
        push_pixel(24'hFFFFFF, 1'b1);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);

        // limit above the palette size saturates; black as key
        wait_idle();
        write_reg(ecpi_pkg::REG_COLOR_LIMIT, 24'd31);
        write_reg(ecpi_pkg::REG_TRANSP_COLOR, 24'h000000);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'hAAAAAA, 1'b0);
        push_pixel(24'h555555, 1'b0);
        push_pixel(24'hAAAAAA, 1'b0);
        push_pixel(24'h000000, 1'b0);

        // limit one with transparency off
        wait_idle();
        write_reg(ecpi_pkg::REG_COLOR_LIMIT, 24'd1);
        write_reg(ecpi_pkg::REG_TRANSP_EN, 24'd0);
        push_pixel(24'h555555, 1'b0);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'h010203, 1'b0);

        // random images from small color pools under a sweep of settings
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:       limit_pick = 5'd16;
                1:       limit_pick = 5'd31;
                2:       limit_pick = 5'd0;
                3:       limit_pick = 5'd1;
                4:       limit_pick = 5'd15;
                5:       limit_pick = 5'd17;
                6:       limit_pick = 5'd2;
                default: limit_pick = ecpi_pkg::LIMIT_W'($urandom_range(31));
            endcase
            key_on = ($urandom_range(9) < 6);
            if ($urandom_range(3) == 0) begin
                key_pick = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            end else begin
                key_pick = ecpi_pkg::COLOR_W'($urandom);
            end
            write_reg(ecpi_pkg::REG_COLOR_LIMIT, ecpi_pkg::CFG_DATA_W'(limit_pick));
            write_reg(ecpi_pkg::REG_TRANSP_EN, ecpi_pkg::CFG_DATA_W'(key_on));
            write_reg(ecpi_pkg::REG_TRANSP_COLOR, key_pick);
            steady_stretch = (phase == 4);
            if (phase == 6) begin
                hold_request = 1'b1;
            end

            phase_count = 0;
            while (phase_count < PHASE_PIXELS) begin
                pool_n = $urandom_range(1, POOL_MAX);
                for (int k = 0; k < pool_n; k++) begin
                    color_pool[k] = {pick_channel(), pick_channel(), pick_channel()};
                end
                if ($urandom_range(2) == 0) begin
                    color_pool[0] = key_pick;
                end
                image_len = $urandom_range(4, 40);
                // last image of a phase is cut to the phase budget
                if (image_len > PHASE_PIXELS - phase_count) begin
                    image_len = PHASE_PIXELS - phase_count;
                end
                for (int k = 0; k < image_len; k++) begin
                    // mostly pool colors; a few stray colors and stray image starts
                    if ($urandom_range(99) < 6) begin
                        rgb = ecpi_pkg::COLOR_W'($urandom);
                    end else begin
                        rgb = color_pool[$urandom_range(pool_n - 1)];
                    end
                    if (k == 0) begin
                        sof = ($urandom_range(9) != 0);
                    end else begin
                        sof = ($urandom_range(99) < 2);
                    end
                    push_pixel(rgb, sof);
                end
                phase_count += image_len;
            end
            steady_stretch = 1'b0;
        end

        // drain and decide
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        spent = 0;
        while (pending != 0 && spent < END_LIMIT) begin
            @(negedge i_clk);
            spent++;
        end
        repeat (2 * MAX_ENTRIES) @(negedge i_clk);

        $display("Sent %0d pixels over %0d register writes: %0d indexed, %0d transparent,",
                 pixels_sent, reg_writes, indexed, skipped,
                 " %0d overflowed, %0d appended", overflows, appends);
        $display("Result errors: %0d, results still outstanding: %0d", mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/ecpi_pkg.sv
src/ecpi_ifs.sv
src/ecpi_cell.sv
src/exact_color_palette_indexer.sv
tb/palette_index_checker.sv
tb/exact_color_palette_indexer_test.sv
